// ----- design/serial_frame_receiver_top_defines.svh -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_top_defines.svh
// Assertion macros shared by the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Number of check bytes between payload and stop byte
    localparam int SFR_CHECK_BYTES = 4;

    // Configuration register indexes
    localparam int            CFG_IDX_W     = 2;
    localparam [CFG_IDX_W-1:0] CFG_START    = 2'd0;
    localparam [CFG_IDX_W-1:0] CFG_STOP     = 2'd1;
    localparam [CFG_IDX_W-1:0] CFG_ACK      = 2'd2;
    localparam [CFG_IDX_W-1:0] CFG_NACK     = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_START_BYTE = 8'd2;
    localparam logic [7:0] RST_STOP_BYTE  = 8'd4;
    localparam logic [7:0] RST_ACK_TYPE   = 8'd6;
    localparam logic [7:0] RST_NACK_TYPE  = 8'd21;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_DATA      = 3'd1;
    localparam logic [2:0] KIND_ACK       = 3'd2;
    localparam logic [2:0] KIND_NACK      = 3'd3;
    localparam logic [2:0] KIND_BAD_STOP  = 3'd4;
    localparam logic [2:0] KIND_ZERO_TYPE = 3'd5;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] ack_type;
        logic [7:0] nack_type;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic [31:0] frame_check;
    } t_result;

endpackage

// ----- design/sfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register bank, written by index over the config channel.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [7:0]                   i_data,
    output sfr_pkg::t_cfg                o_cfg
);
    import sfr_pkg::*;

    t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= RST_START_BYTE;
            r_cfg.stop_byte  <= RST_STOP_BYTE;
            r_cfg.ack_type   <= RST_ACK_TYPE;
            r_cfg.nack_type  <= RST_NACK_TYPE;
        end else if (i_wr) begin
            case (i_idx)
                CFG_START: r_cfg.start_byte <= i_data;
                CFG_STOP:  r_cfg.stop_byte  <= i_data;
                CFG_ACK:   r_cfg.ack_type   <= i_data;
                CFG_NACK:  r_cfg.nack_type  <= i_data;
                default:   r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/sfr_parser.sv -----
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state machine: consumes one byte per advance, emits zero or one result.
// ----------------------------------------------------------------------------
module sfr_parser #(
    parameter int CHECK_BYTES = sfr_pkg::SFR_CHECK_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    input  sfr_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;
    localparam logic [2:0] PH_STOP   = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_type,  n_type;
    logic [7:0]  r_len,   n_len;
    logic [31:0] r_check, n_check;
    logic [7:0]  cnt_inc;
    logic        res_valid;
    t_result     res;

    assign cnt_inc = r_count + 8'd1;

    // Next state and result for the byte at the parser input
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_type    = r_type;
        n_len     = r_len;
        n_check   = r_check;
        res_valid = 1'b0;
        res       = '0;
        case (r_phase)
            PH_TYPE: begin
                n_type = i_byte;
                if (i_byte == 8'd0) begin
                    n_phase   = PH_HUNT;
                    res_valid = 1'b1;
                    res.kind  = KIND_ZERO_TYPE;
                end else begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_len   = i_byte;
                n_count = 8'd0;
                n_check = '0;
                n_phase = (i_byte != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = i_byte;
                res.payload_index = r_count;
                res.frame_type    = r_type;
                res.frame_length  = r_len;
                if (cnt_inc >= r_len) begin
                    n_count = 8'd0;
                    n_phase = PH_CHECK;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_CHECK: begin
                n_check = {r_check[23:0], i_byte};
                if (cnt_inc >= 8'(CHECK_BYTES)) begin
                    n_count = 8'd0;
                    n_phase = PH_STOP;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_STOP: begin
                res_valid        = 1'b1;
                res.frame_type   = r_type;
                res.frame_length = r_len;
                res.frame_check  = r_check;
                if (i_byte != i_cfg.stop_byte) begin
                    res.kind = KIND_BAD_STOP;
                end else if (r_type == i_cfg.ack_type && r_len == 8'd0) begin
                    res.kind = KIND_ACK;
                end else if (r_type == i_cfg.nack_type && r_len == 8'd0) begin
                    res.kind = KIND_NACK;
                end else begin
                    res.kind = KIND_DATA;
                end
                n_phase = PH_HUNT;
                n_count = 8'd0;
            end
            default: begin
                // hunting: anything but the start byte is dropped
                if (i_byte == i_cfg.start_byte) begin
                    n_phase = PH_TYPE;
                    n_count = 8'd0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // State update on each advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= 8'd0;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_check <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_type  <= n_type;
            r_len   <= n_len;
            r_check <= n_check;
        end
    end

    assign o_res_valid = i_adv & res_valid;
    assign o_res       = res;

endmodule

// ----- design/sfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register with one skid entry driving the master stream.
// ----------------------------------------------------------------------------
module sfr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfr_pkg::t_result i_res,
    output logic             o_full,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser
);
    import sfr_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_v & m_axis_tready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            r_out_v  <= r_skid_v | i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_full        = r_skid_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.frame_check, r_out.frame_length, r_out.frame_type,
                            r_out.payload_index, r_out.payload_byte};

endmodule

// ----- design/serial_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// Length-prefixed frame receiver: start, type, length, payload, check, stop.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one received byte per transfer. Master stream gives
//   one result per payload byte (tuser kind payload) and one status result
//   at the stop position (data, ack, nack, bad stop) or on a zero type byte.
//   Bytes outside a frame, header bytes and check bytes give no result.
//   Config channel (i_cfg_*) sets start byte, stop byte, ack and nack types;
//   it is always ready and must be used only while the block is idle.
//   Results pass the input register, then the result register, before they
//   are offered on the master stream. Throughput: one byte per cycle while
//   the skid entry is empty, set by the combinational frame state machine
//   between the two registers.
//   Reset: parser returns to hunting for the start byte, config registers
//   take their defaults, output stage empties.
//   Stall: while m_axis_tready is low the result register holds, one more
//   result goes to a skid entry and the input register fills; then
//   s_axis_tready drops until the master side drains.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top #(
    parameter int CHECK_BYTES = sfr_pkg::SFR_CHECK_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream: tdata[7:0] rx_byte
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    // master stream: tdata[7:0] payload_byte, [15:8] payload_index,
    // [23:16] frame_type, [31:24] frame_length, [63:32] frame_check
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,
    // tuser[2:0] kind
    output logic [2:0]                    m_axis_tuser,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import sfr_pkg::*;

    logic    r_in_v;
    logic [7:0] r_in_byte;
    logic    adv;
    logic    out_full;
    logic    res_valid;
    t_result res;
    t_cfg    cfg;

    assign o_cfg_ready   = 1'b1;
    assign adv           = r_in_v & ~out_full;
    assign s_axis_tready = ~r_in_v | adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sfr_parser #(
        .CHECK_BYTES (CHECK_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfr_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (res_valid),
        .i_res         (res),
        .o_full        (out_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- design/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_top_defines.svh"

module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import sfr_pkg::*;

    // Kind stays in its defined range
    `SFR_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tuser <= KIND_ZERO_TYPE, "kind out of range")

    // Payload results carry no check bytes yet
    `SFR_ASSERT_IMP(a_payload_no_check, m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD, m_axis_tdata[63:32] == 32'd0, "check field set on payload")

    // Zero-type error carries all-zero fields
    `SFR_ASSERT_IMP(a_zero_type_clear, m_axis_tvalid && m_axis_tuser == KIND_ZERO_TYPE, m_axis_tdata == 64'd0, "zero-type result not clear")

    // Ack and nack only for empty frames
    `SFR_ASSERT_IMP(a_ack_empty, m_axis_tvalid && (m_axis_tuser == KIND_ACK || m_axis_tuser == KIND_NACK), m_axis_tdata[31:24] == 8'd0, "ack or nack with payload")

    // Stalled result holds
    `SFR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (.*);

// ----- dv/serial_frame_receiver_top_test.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_top_test
// Self-checking bench for the frame receiver. A byte queue feeds a stream
// driver, and every accepted byte goes through a behavioral frame parser that
// queues the results it should cause. A monitor takes the results under random
// backpressure and compares each field with the oldest queued one. The run
// covers several start, stop, ack and nack settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module serial_frame_receiver_top_test;
    import sfr_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int DRAIN_CYCLES     = 8;
    localparam int QUIET_LIMIT      = 3000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int PHASE_BYTES      = 110;
    localparam int NUM_PHASES       = 6;

    typedef enum logic [2:0] {
        P_HUNT, P_TYPE, P_LENGTH, P_PAYLOAD, P_CHECK, P_STOP
    } t_parse_phase;

    typedef enum int {PACE_NONE, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [7:0]           i_cfg_data    = '0;

    serial_frame_receiver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Parser mirror: register copy and frame state
    t_cfg         rx_cfg;
    t_parse_phase parse_phase;
    logic [7:0]   byte_cnt;
    logic [7:0]   frame_type;
    logic [7:0]   frame_len;
    logic [31:0]  frame_chk;

    t_result      frame_results_due[$];
    logic [7:0]   rx_line_bytes[$];

    t_pace        tx_pace;
    t_pace        rx_pace;
    int           tx_wait;
    int           rx_wait;
    int           hold_left      = 0;
    bit           long_hold_req  = 1'b0;
    bit           long_hold_done = 1'b0;
    int           error_count    = 0;
    int           quiet_cycles   = 0;

    function automatic int draw_wait(input t_pace pace);
        case (pace)
            PACE_NONE:   return 0;
            PACE_RANDOM: return $urandom_range(0, 11);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    function automatic t_result make_result(input logic [2:0] kind, input logic [7:0] pbyte,
                                            input logic [7:0] pidx, input logic [7:0] ftype,
                                            input logic [7:0] flen, input logic [31:0] fchk);
        t_result r;
        r.kind          = kind;
        r.payload_byte  = pbyte;
        r.payload_index = pidx;
        r.frame_type    = ftype;
        r.frame_length  = flen;
        r.frame_check   = fchk;
        return r;
    endfunction

    // Advance the frame parser by one byte; queue any result it causes
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [2:0] kind;
        case (parse_phase)
            P_HUNT: begin
                // anything but the start byte is dropped
                if (b == rx_cfg.start_byte) begin
                    parse_phase = P_TYPE;
                    byte_cnt    = '0;
                end
            end
            P_TYPE: begin
                frame_type = b;
                if (b == 8'd0) begin
                    parse_phase = P_HUNT;
                    frame_results_due.push_back(make_result(KIND_ZERO_TYPE, '0, '0, '0, '0, '0));
                end else begin
                    parse_phase = P_LENGTH;
                end
            end
            P_LENGTH: begin
                frame_len   = b;
                byte_cnt    = '0;
                frame_chk   = '0;
                parse_phase = (b != 8'd0) ? P_PAYLOAD : P_CHECK;
            end
            P_PAYLOAD: begin
                frame_results_due.push_back(make_result(KIND_PAYLOAD, b, byte_cnt, frame_type,
                                                        frame_len, '0));
                byte_cnt = byte_cnt + 8'd1;
                if (byte_cnt >= frame_len) begin
                    byte_cnt    = '0;
                    parse_phase = P_CHECK;
                end
            end
            P_CHECK: begin
                frame_chk = {frame_chk[23:0], b};
                byte_cnt  = byte_cnt + 8'd1;
                if (byte_cnt >= SFR_CHECK_BYTES) begin
                    byte_cnt    = '0;
                    parse_phase = P_STOP;
                end
            end
            default: begin
                // stop position: empty frames of the ack type win over nack
                if (b != rx_cfg.stop_byte)
                    kind = KIND_BAD_STOP;
                else if (frame_type == rx_cfg.ack_type && frame_len == 8'd0)
                    kind = KIND_ACK;
                else if (frame_type == rx_cfg.nack_type && frame_len == 8'd0)
                    kind = KIND_NACK;
                else
                    kind = KIND_DATA;
                frame_results_due.push_back(make_result(kind, '0, '0, frame_type, frame_len,
                                                        frame_chk));
                parse_phase = P_HUNT;
                byte_cnt    = '0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Sender: one byte per transfer, random gaps between bytes unless the pace is none
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait     = 0;
            parse_phase = P_HUNT;
            byte_cnt    = '0;
            frame_type  = '0;
            frame_len   = '0;
            frame_chk   = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_rx_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_line_bytes.size() != 0) begin
                    s_axis_tdata  <= rx_line_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    // keep pushing while the receiver is held off
                    tx_wait = (hold_left > 0) ? 0 : draw_wait(tx_pace);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind          = m_axis_tuser;
                got.payload_byte  = m_axis_tdata[7:0];
                got.payload_index = m_axis_tdata[15:8];
                got.frame_type    = m_axis_tdata[23:16];
                got.frame_length  = m_axis_tdata[31:24];
                got.frame_check   = m_axis_tdata[63:32];
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d data 0x%h",
                             $time, got.kind, m_axis_tdata);
                    error_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(got.payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(got.payload_index));
                    check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(got.frame_length));
                    check_field("frame_check", want.frame_check, got.frame_check);
                end
                rx_wait = draw_wait(rx_pace);
            end
            if (long_hold_req && !long_hold_done) begin
                hold_left      <= LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
                ready_next = 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                ready_next = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    // Watchdog: too long without any transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("serial_frame_receiver_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_START: rx_cfg.start_byte = val;
            CFG_STOP:  rx_cfg.stop_byte  = val;
            CFG_ACK:   rx_cfg.ack_type   = val;
            CFG_NACK:  rx_cfg.nack_type  = val;
        endcase
    endtask

    // Wait for all bytes sent and all results back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (rx_line_bytes.size() != 0 || s_axis_tvalid || frame_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] len,
                               input bit stop_ok);
        rx_line_bytes.push_back(rx_cfg.start_byte);
        rx_line_bytes.push_back(ftype);
        if (ftype == 8'd0)
            return;
        rx_line_bytes.push_back(len);
        repeat (int'(len) + SFR_CHECK_BYTES)
            rx_line_bytes.push_back(8'($urandom_range(0, 255)));
        rx_line_bytes.push_back(stop_ok ? rx_cfg.stop_byte
                                        : rx_cfg.stop_byte ^ 8'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed frames with random content, some noise and cut frames
    task automatic queue_random_frame();
        int         pick;
        logic [7:0] ftype;
        logic [7:0] len;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            repeat ($urandom_range(1, 4))
                rx_line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (pick == 2) begin
            // header promises more payload than follows
            rx_line_bytes.push_back(rx_cfg.start_byte);
            rx_line_bytes.push_back(8'($urandom_range(1, 255)));
            rx_line_bytes.push_back(8'($urandom_range(4, 12)));
            repeat ($urandom_range(0, 3))
                rx_line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 9))
            0:       ftype = 8'd0;
            1, 2:    ftype = rx_cfg.ack_type;
            3, 4:    ftype = rx_cfg.nack_type;
            default: ftype = 8'($urandom_range(1, 255));
        endcase
        if ($urandom_range(0, 49) == 0)
            len = 8'($urandom_range(100, 255));
        else if ((ftype == rx_cfg.ack_type || ftype == rx_cfg.nack_type)
                 && $urandom_range(0, 2) != 0)
            len = 8'd0;
        else
            len = 8'($urandom_range(0, 8));
        queue_frame(ftype, len, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        t_cfg       setting;
        int         phase_no;
        logic [7:0] opening [26];
        // Noise, zero type, empty ack, empty nack, two-byte data frame with a
        // bad stop; all under the reset register values
        opening = '{8'h00, 8'hFF,
                    RST_START_BYTE, 8'h00,
                    RST_START_BYTE, RST_ACK_TYPE, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
                    RST_STOP_BYTE,
                    RST_START_BYTE, RST_NACK_TYPE, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55,
                    RST_STOP_BYTE,
                    RST_START_BYTE, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h80};

        rx_cfg.start_byte = RST_START_BYTE;
        rx_cfg.stop_byte  = RST_STOP_BYTE;
        rx_cfg.ack_type   = RST_ACK_TYPE;
        rx_cfg.nack_type  = RST_NACK_TYPE;
        tx_pace = PACE_RANDOM;
        rx_pace = PACE_BURSTY;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening[i])
            rx_line_bytes.push_back(opening[i]);
        // rest of the data frame: check bytes and a wrong stop byte
        rx_line_bytes.push_back(8'h01);
        rx_line_bytes.push_back(8'h7F);
        rx_line_bytes.push_back(8'hFE);
        rx_line_bytes.push_back(RST_STOP_BYTE ^ 8'h01);
        wait_idle();

        for (phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
            case (phase_no)
                0: setting = '{start_byte: RST_START_BYTE, stop_byte: RST_STOP_BYTE,
                               ack_type: RST_ACK_TYPE, nack_type: RST_NACK_TYPE};
                1: setting = '{start_byte: 8'h00, stop_byte: 8'hFF,
                               ack_type: 8'h01, nack_type: 8'hFF};
                2: setting = '{start_byte: 8'hFF, stop_byte: 8'h00,
                               ack_type: 8'hFF, nack_type: 8'h01};
                3: setting = '{start_byte: 8'h7E, stop_byte: 8'h7E,
                               ack_type: 8'h33, nack_type: 8'h33};
                default: setting = t_cfg'($urandom());
            endcase
            write_reg(CFG_START, setting.start_byte);
            write_reg(CFG_STOP, setting.stop_byte);
            write_reg(CFG_ACK, setting.ack_type);
            write_reg(CFG_NACK, setting.nack_type);
            @(negedge i_clk);

            tx_pace = t_pace'(phase_no % 3);
            rx_pace = t_pace'((phase_no + 1) % 3);
            // one long receiver hold-off while the sender keeps going
            if (phase_no == 2)
                long_hold_req = 1'b1;

            queue_frame(rx_cfg.ack_type, 8'd0, 1'b1);
            queue_frame(rx_cfg.nack_type, 8'd0, 1'b1);
            queue_frame(rx_cfg.ack_type, 8'd1, 1'b1);
            queue_frame(8'($urandom_range(1, 255)), 8'd3, 1'b0);
            // longest payload once, reaching the top payload index
            if (phase_no == 1)
                queue_frame(8'h40, 8'd255, 1'b1);
            while (rx_line_bytes.size() < PHASE_BYTES)
                queue_random_frame();
            wait_idle();
        end

        if (error_count == 0 && frame_results_due.size() == 0) begin
            $display("serial_frame_receiver_top verification clean");
        end else begin
            $display("serial_frame_receiver_top verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/sfr_pkg.sv
design/sfr_cfg_regs.sv
design/sfr_parser.sv
design/sfr_out_stage.sv
design/serial_frame_receiver_top.sv
design/sfr_checker.sv
dv/serial_frame_receiver_top_test.sv
